[sv/brc_pkg.sv]
// Package: types and constants for barometer reading compensation.
package brc_pkg;

    localparam int unsigned CFG_W  = 64;
    localparam int unsigned IDX_W  = 2;

    localparam logic [IDX_W-1:0] REG_OFFSET = 2'd0;
    localparam logic [IDX_W-1:0] REG_SCALE  = 2'd1;
    localparam logic [IDX_W-1:0] REG_TEMP   = 2'd2;
    localparam logic [IDX_W-1:0] REG_OSS    = 2'd3;

    localparam logic [31:0] C_B6_OFS  = 32'd4000;
    localparam logic [31:0] C_B4_OFS  = 32'd32768;
    localparam logic [31:0] C_B7_SCL  = 32'd50000;
    localparam logic [31:0] C_P_SQ    = 32'd3038;
    localparam logic [31:0] C_P_LIN   = 32'hFFFF_E343;
    localparam logic [31:0] C_P_OFS   = 32'd3791;
    localparam logic [31:0] C_MC_SCL  = 32'd2048;

    // Multiply operand selects, one per sequencer step
    typedef enum logic [3:0] {
        M_T_X1, M_T_MC, M_P_SQ, M_P_B2, M_P_AC2, M_P_AC3, M_P_B1, M_P_B4,
        M_P_B7, M_P_PP, M_P_PK, M_P_PL
    } mstep_t;

endpackage

[sv/barometer_reading_compensation.sv]
// Top level: barometer reading compensation with serial multiplier and divider.
// A temperature or pressure item runs from the input transfer to m_valid
// through a bit-serial shift-add multiplier, with a setup and post step per
// product, and a restoring divider. A new item is taken only in idle, once the
// last result has moved to the output registers; a held result stalls the
// sequencer only once the next result is ready.
// Reset: synchronous active-low aresetn clears control, config, b5 and output regs.
module barometer_reading_compensation
    import brc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_req_type,
    input  logic [18:0]       s_raw_sample,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_result_kind,
    output logic signed [31:0] m_value,
    output logic              m_fault
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SET  = 7'b0000010,
        ST_MUL  = 7'b0000100,
        ST_POST = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_DPST = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    mstep_t      step_reg, step_next;
    logic [47:0] offs_reg;
    logic [47:0] scl_reg;
    logic [63:0] tco_reg;
    logic [1:0]  oss_reg;
    logic [31:0] b5_reg;
    logic        kind_reg;
    logic [31:0] raw_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] ma_reg, mb_reg, acc_reg;
    logic [31:0] b6_reg, sq_reg, x1_reg, b3_reg, b4_reg, p_reg, t_reg;
    logic [31:0] dn_reg, dd_reg, dq_reg, drm_reg;
    logic        dsgn_reg, fault_reg;
    logic        ov_reg;
    logic        mv_reg;
    logic        mk_reg;
    logic [31:0] mval_reg;
    logic        mf_reg;

    logic [31:0] ac1, ac2, b2, ac3, ac4, b1, ac5, ac6, mc, md;
    assign ac1 = {{16{offs_reg[15]}}, offs_reg[15:0]};
    assign ac2 = {{16{offs_reg[31]}}, offs_reg[31:16]};
    assign b2  = {{16{offs_reg[47]}}, offs_reg[47:32]};
    assign ac3 = {{16{scl_reg[15]}}, scl_reg[15:0]};
    assign ac4 = {16'd0, scl_reg[31:16]};
    assign b1  = {{16{scl_reg[47]}}, scl_reg[47:32]};
    assign ac5 = {16'd0, tco_reg[15:0]};
    assign ac6 = {16'd0, tco_reg[31:16]};
    assign mc  = {{16{tco_reg[47]}}, tco_reg[47:32]};
    assign md  = {{16{tco_reg[63]}}, tco_reg[63:48]};

    function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
        asr = 32'($signed(v) >>> s);
    endfunction

    logic [31:0] op_a, op_b;
    logic [31:0] b7s;
    always_comb begin
        b7s = C_B7_SCL >> oss_reg;
        op_a = '0;
        op_b = '0;
        case (step_reg)
            M_T_X1:  begin op_a = raw_reg - ac6; op_b = ac5; end
            M_T_MC:  begin op_a = mc;            op_b = C_MC_SCL; end
            M_P_SQ:  begin op_a = b6_reg;        op_b = b6_reg; end
            M_P_B2:  begin op_a = b2;            op_b = sq_reg; end
            M_P_AC2: begin op_a = ac2;           op_b = b6_reg; end
            M_P_AC3: begin op_a = ac3;           op_b = b6_reg; end
            M_P_B1:  begin op_a = b1;            op_b = sq_reg; end
            M_P_B4:  begin op_a = ac4;           op_b = t_reg + C_B4_OFS; end
            M_P_B7:  begin op_a = raw_reg - b3_reg; op_b = b7s; end
            M_P_PP:  begin op_a = asr(p_reg, 5'd8); op_b = asr(p_reg, 5'd8); end
            M_P_PK:  begin op_a = t_reg;         op_b = C_P_SQ; end
            M_P_PL:  begin op_a = C_P_LIN;       op_b = p_reg; end
            default: begin op_a = '0;            op_b = '0; end
        endcase
    end

    // divider trial subtract
    logic [32:0] rem_sh, rem_sub;
    assign rem_sh  = {drm_reg, dn_reg[31]};
    assign rem_sub = rem_sh - {1'b0, dd_reg};

    logic [31:0] qfix, pq, dw, b5w;
    assign qfix = dsgn_reg ? (32'd0 - dq_reg) : dq_reg;
    assign pq   = ov_reg ? {dq_reg[30:0], 1'b0} : dq_reg;
    assign dw   = x1_reg + md;
    assign b5w  = x1_reg + ((dd_reg == 32'd0) ? 32'd0 : qfix);

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        step_next = step_reg;
        case (state_reg)
            ST_IDLE: if (s_valid && s_ready) begin
                state_next = ST_SET;
                step_next  = s_req_type ? M_P_SQ : M_T_X1;
            end
            ST_SET:  state_next = ST_MUL;
            ST_MUL:  if (cnt_reg == 5'd31) state_next = ST_POST;
            ST_POST: begin
                case (step_reg)
                    M_T_MC:  state_next = ST_DIV;
                    M_P_B7:  begin
                        state_next = ST_DIV;
                        step_next  = M_P_PP;
                    end
                    M_P_PL:  state_next = ST_OUT;
                    default: begin
                        state_next = ST_SET;
                        step_next  = mstep_t'(step_reg + 4'd1);
                    end
                endcase
            end
            ST_DIV:  if (cnt_reg == 5'd31) state_next = ST_DPST;
            ST_DPST: state_next = (kind_reg == 1'b0) ? ST_OUT : ST_SET;
            ST_OUT:  if (!mv_reg) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= M_T_X1;
            offs_reg  <= '0;
            scl_reg   <= '0;
            tco_reg   <= '0;
            oss_reg   <= '0;
            b5_reg    <= '0;
            mv_reg    <= 1'b0;
            mk_reg    <= 1'b0;
            mf_reg    <= 1'b0;
            mval_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_OFFSET: offs_reg <= cfg_data[47:0];
                    REG_SCALE:  scl_reg  <= cfg_data[47:0];
                    REG_TEMP:   tco_reg  <= cfg_data;
                    REG_OSS:    oss_reg  <= cfg_data[1:0];
                    default:    ;
                endcase
            end
            if (m_valid && m_ready) begin
                mv_reg <= 1'b0;
            end else if (state_reg == ST_OUT) begin
                mv_reg <= 1'b1;
            end
            case (state_reg)
                ST_IDLE: if (s_valid && s_ready) begin
                    kind_reg  <= s_req_type;
                    raw_reg   <= {13'd0, s_raw_sample};
                    fault_reg <= 1'b0;
                    b6_reg    <= b5_reg - C_B6_OFS;
                end
                ST_SET: begin
                    ma_reg  <= op_a;
                    mb_reg  <= op_b;
                    acc_reg <= '0;
                    cnt_reg <= '0;
                end
                ST_MUL: begin
                    // shift-add one multiplier bit per cycle
                    if (mb_reg[0]) acc_reg <= acc_reg + ma_reg;
                    ma_reg  <= {ma_reg[30:0], 1'b0};
                    mb_reg  <= {1'b0, mb_reg[31:1]};
                    cnt_reg <= cnt_reg + 5'd1;
                end
                ST_POST: begin
                    cnt_reg <= '0;
                    drm_reg <= '0;
                    dq_reg  <= '0;
                    case (step_reg)
                        M_T_X1:  x1_reg <= asr(acc_reg, 5'd15);
                        M_T_MC:  begin
                            dsgn_reg <= acc_reg[31] ^ dw[31];
                            dn_reg   <= acc_reg[31] ? 32'd0 - acc_reg : acc_reg;
                            dd_reg   <= dw[31] ? 32'd0 - dw : dw;
                            ov_reg   <= 1'b0;
                        end
                        M_P_SQ:  sq_reg <= asr(acc_reg, 5'd12);
                        M_P_B2:  x1_reg <= asr(acc_reg, 5'd11);
                        M_P_AC2: begin
                            b3_reg <= asr(((32'(ac1 << 2) + x1_reg + asr(acc_reg, 5'd11))
                                      << oss_reg) + 32'd2, 5'd2);
                        end
                        M_P_AC3: x1_reg <= asr(acc_reg, 5'd13);
                        M_P_B1:  t_reg <= asr(x1_reg + asr(acc_reg, 5'd16) + 32'd2, 5'd2);
                        M_P_B4:  b4_reg <= acc_reg >> 15;
                        M_P_B7:  begin
                            dsgn_reg <= 1'b0;
                            ov_reg   <= acc_reg[31];
                            dn_reg   <= acc_reg[31] ? acc_reg : {acc_reg[30:0], 1'b0};
                            dd_reg   <= b4_reg;
                        end
                        M_P_PP:  t_reg <= acc_reg;
                        M_P_PK:  x1_reg <= asr(acc_reg, 5'd16);
                        M_P_PL:  begin
                            p_reg <= p_reg + asr(x1_reg + asr(acc_reg, 5'd16) + C_P_OFS,
                                                 5'd4);
                        end
                        default: ;
                    endcase
                end
                ST_DIV: begin
                    if (!rem_sub[32]) begin
                        drm_reg <= rem_sub[31:0];
                        dq_reg  <= {dq_reg[30:0], 1'b1};
                    end else begin
                        drm_reg <= rem_sh[31:0];
                        dq_reg  <= {dq_reg[30:0], 1'b0};
                    end
                    dn_reg  <= {dn_reg[30:0], 1'b0};
                    cnt_reg <= cnt_reg + 5'd1;
                end
                ST_DPST: begin
                    if (dd_reg == 32'd0) fault_reg <= 1'b1;
                    if (kind_reg == 1'b0) begin
                        b5_reg <= b5w;
                        p_reg  <= asr(b5w + 32'd8, 5'd4);
                    end else begin
                        p_reg <= (dd_reg == 32'd0) ? 32'd0 : pq;
                    end
                end
                ST_OUT: if (!mv_reg) begin
                    mk_reg   <= kind_reg;
                    mf_reg   <= fault_reg;
                    mval_reg <= p_reg;
                end
                default: ;
            endcase
        end
    end

    assign m_valid       = mv_reg;
    assign m_result_kind = mk_reg;
    assign m_value       = mval_reg;
    assign m_fault       = mf_reg;

endmodule
